### rtl/bfba_pkg.sv
// Shared types and constants for the best-fit block allocator.
// Depends on nothing; every rtl file imports it.
package bfba_pkg;

   // Sizes of the heap, the free-block table and the stale queue
   localparam int MAX_SLOTS   = 1024;
   localparam int TBL_DEPTH   = 512;
   localparam int FIFO_DEPTH  = 64;
   localparam int TBL_AW      = $clog2(TBL_DEPTH);
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int SLOT_W      = 11;
   localparam int OFF_W       = 10;
   localparam int END_W       = SLOT_W + 1;
   localparam int FRAME_W     = 64;
   localparam int ADDR_W      = 64;
   localparam int STRIDE_W    = 9;
   localparam int PROD_W      = OFF_W + STRIDE_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   // Operation codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE    = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [SLOT_W-1:0]  request_count;
      logic [OFF_W-1:0]   block_offset;
      logic [FRAME_W-1:0] frame_number;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [OFF_W-1:0]  granted_offset;
      logic [SLOT_W-1:0] granted_count;
      logic [ADDR_W-1:0] descriptor_handle;
      logic [SLOT_W-1:0] free_total;
      logic [SLOT_W-1:0] largest_free_block;
   } rsp_type;

   // One free-block table entry
   typedef struct packed {
      logic              vld;
      logic [OFF_W-1:0]  off;
      logic [SLOT_W-1:0] len;
   } entry_type;

   // One stale queue entry
   typedef struct packed {
      logic [OFF_W-1:0]   off;
      logic [SLOT_W-1:0]  len;
      logic [FRAME_W-1:0] frame;
   } stale_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_sts_type;

endpackage

### rtl/bfba_stale_fifo.sv
// Stale queue: blocks waiting for their frame to complete, with frame tags.
// Depends on bfba_pkg.
module bfba_stale_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  bfba_pkg::fifo_ctl_type ctl,
   input  bfba_pkg::stale_type    push_data,
   output bfba_pkg::stale_type    head_data,
   output bfba_pkg::fifo_sts_type sts
);
   import bfba_pkg::*;

   stale_type            mem [FIFO_DEPTH];
   stale_type            rd_ff;
   logic [FIFO_AW-1:0]   head_ff, head_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic [FIFO_AW-1:0]   tail;

   assign tail      = head_ff + count_ff[FIFO_AW-1:0];
   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign head_data = rd_ff;

   // Advance pointers on push and pop
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else begin
         if (ctl.pop) begin
            head_in = head_ff + 1'b1;
         end
         case ({ctl.push, ctl.pop})
            2'b10:   count_in = count_ff + 1'b1;
            2'b01:   count_in = count_ff - 1'b1;
            default: count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Write at the tail, read the head every cycle
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail] <= push_data;
      end
      rd_ff <= mem[head_ff];
   end

endmodule

### rtl/best_fit_block_allocator_core.sv
// Best-fit slot allocator with deferred free queue and coalescing.
// Depends on bfba_pkg and bfba_stale_fifo.
//
//  port group | direction | carries
//  req_*      | in        | allocate / free / release item
//  rsp_*      | out       | one result item per request item
//  csr_*      | in        | heap_size, base_address, handle_stride writes
//
// Allocate: one 512-entry table scan, the update states S_AUPD and S_AHDL,
// then one 512-entry scan for the largest block. Free: straight to the result.
// Release: per queued block a head read, a check and, for a valid block, a 512-entry scan, then the largest-block scan.
// Every scan reads the single table port once per entry.
// After reset and after each heap_size write a clearing pass over all 512
// entries runs and no item is accepted. A full rsp register holds the next result.
module best_fit_block_allocator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bfba_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bfba_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [bfba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfba_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bfba_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ASCAN, S_AUPD, S_AHDL,
      S_RHEAD, S_RCHK, S_RSCAN, S_RUPD2, S_LSCAN, S_RESP
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic [SLOT_W-1:0]  hs_ff, free_ff, largest_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [TBL_AW:0]    clr_cnt_ff;
   logic [1:0]         status_ff;
   logic [OFF_W-1:0]   gnt_off_ff;
   logic [SLOT_W-1:0]  gnt_cnt_ff;
   logic [ADDR_W-1:0]  handle_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // scan unit
   logic [TBL_AW:0]    scan_cnt_ff;
   logic               chk_vld_ff;
   logic [TBL_AW-1:0]  chk_idx_ff;
   entry_type          tbl_rd_ff;
   logic               best_found_ff, prev_found_ff, next_found_ff, hole_found_ff, ovl_ff;
   logic [TBL_AW-1:0]  best_idx_ff, prev_idx_ff, next_idx_ff, hole_idx_ff;
   logic [OFF_W-1:0]   best_off_ff, prev_off_ff;
   logic [SLOT_W-1:0]  best_len_ff, prev_len_ff, next_len_ff, lg_acc_ff;

   entry_type          tbl_mem [TBL_DEPTH];
   logic               tw_en;
   logic [TBL_AW-1:0]  tw_addr;
   entry_type          tw_data;

   fifo_ctl_type       fifo_ctl;
   fifo_sts_type       fifo_sts;
   stale_type          fifo_head, fifo_push;

   logic               accept, scanning, scan_issue, scan_done, scan_start;
   logic               alloc_ok, rel_take, rel_bad, heap_wr, rel_merge;
   logic [SLOT_W-1:0]  hs_new;
   logic [END_W-1:0]   e_end, b_end;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign heap_wr    = csr_we && (csr_index == CSR_HEAP_SIZE);
   assign hs_new     = (csr_wdata[SLOT_W-1:0] > SLOT_W'(MAX_SLOTS)) ?
                       SLOT_W'(MAX_SLOTS) : csr_wdata[SLOT_W-1:0];
   assign alloc_ok   = (req_data.request_count != '0) &&
                       (req_data.request_count <= free_ff);

   assign scanning   = (state_ff == S_ASCAN) || (state_ff == S_RSCAN) ||
                       (state_ff == S_LSCAN);
   assign scan_issue = scanning && !scan_cnt_ff[TBL_AW];
   assign scan_done  = scanning && scan_cnt_ff[TBL_AW] && !chk_vld_ff;

   // Head of the stale queue against the release frame
   assign rel_take   = !fifo_sts.empty && (fifo_head.frame <= req_ff.frame_number);
   assign b_end      = END_W'(fifo_head.off) + END_W'(fifo_head.len);
   assign rel_bad    = (fifo_head.len == '0) || (b_end > END_W'(hs_ff));
   assign e_end      = END_W'(tbl_rd_ff.off) + END_W'(tbl_rd_ff.len);
   assign rel_merge  = !ovl_ff && (prev_found_ff || next_found_ff || hole_found_ff);

   assign scan_start = (accept && (req_data.operation == OP_ALLOC) && alloc_ok) ||
                       (state_ff == S_AHDL) ||
                       ((state_ff == S_RCHK) && !(rel_take && rel_bad));

   // Queue control
   assign fifo_push.off   = req_data.block_offset;
   assign fifo_push.len   = req_data.request_count;
   assign fifo_push.frame = req_data.frame_number;
   always_comb begin
      fifo_ctl.clear = heap_wr;
      fifo_ctl.push  = accept && (req_data.operation == OP_FREE) && !fifo_sts.full;
      fifo_ctl.pop   = ((state_ff == S_RCHK) && rel_take && rel_bad) ||
                       ((state_ff == S_RSCAN) && scan_done &&
                        !(!ovl_ff && prev_found_ff && next_found_ff)) ||
                       (state_ff == S_RUPD2);
   end

   bfba_stale_fifo u_stale (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_data (fifo_push),
      .head_data (fifo_head),
      .sts       (fifo_sts)
   );

   // Table write port
   always_comb begin
      tw_en   = 1'b0;
      tw_addr = '0;
      tw_data = '0;
      case (state_ff)
         S_CLEAR: begin
            tw_en   = 1'b1;
            tw_addr = clr_cnt_ff[TBL_AW-1:0];
            if (clr_cnt_ff == '0) begin
               tw_data.vld = (hs_ff != '0);
               tw_data.len = hs_ff;
            end
         end
         S_AUPD: begin
            tw_en   = 1'b1;
            tw_addr = best_idx_ff;
            if (best_len_ff != req_ff.request_count) begin
               tw_data.vld = 1'b1;
               tw_data.off = best_off_ff + req_ff.request_count[OFF_W-1:0];
               tw_data.len = best_len_ff - req_ff.request_count;
            end
         end
         S_RSCAN: begin
            if (scan_done && rel_merge) begin
               tw_en       = 1'b1;
               tw_data.vld = 1'b1;
               if (prev_found_ff) begin
                  tw_addr     = prev_idx_ff;
                  tw_data.off = prev_off_ff;
                  tw_data.len = prev_len_ff + fifo_head.len +
                                (next_found_ff ? next_len_ff : '0);
               end else if (next_found_ff) begin
                  tw_addr     = next_idx_ff;
                  tw_data.off = fifo_head.off;
                  tw_data.len = next_len_ff + fifo_head.len;
               end else begin
                  tw_addr     = hole_idx_ff;
                  tw_data.off = fifo_head.off;
                  tw_data.len = fifo_head.len;
               end
            end
         end
         S_RUPD2: begin
            tw_en   = 1'b1;
            tw_addr = next_idx_ff;
         end
         default: tw_en = 1'b0;
      endcase
   end

   // Table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (tw_en) begin
         tbl_mem[tw_addr] <= tw_data;
      end
      tbl_rd_ff <= tbl_mem[scan_cnt_ff[TBL_AW-1:0]];
   end

   // Shared scan unit: one entry compared per cycle
   always_ff @(posedge clock) begin
      if (scan_start) begin
         scan_cnt_ff   <= '0;
         chk_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         prev_found_ff <= 1'b0;
         next_found_ff <= 1'b0;
         hole_found_ff <= 1'b0;
         ovl_ff        <= 1'b0;
         lg_acc_ff     <= '0;
      end else begin
         chk_vld_ff <= scan_issue;
         chk_idx_ff <= scan_cnt_ff[TBL_AW-1:0];
         if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (chk_vld_ff) begin
            case (state_ff)
               S_ASCAN: begin
                  if (tbl_rd_ff.vld && (tbl_rd_ff.len >= req_ff.request_count) &&
                      (!best_found_ff || (tbl_rd_ff.len < best_len_ff) ||
                       ((tbl_rd_ff.len == best_len_ff) &&
                        (tbl_rd_ff.off < best_off_ff)))) begin
                     best_found_ff <= 1'b1;
                     best_idx_ff   <= chk_idx_ff;
                     best_off_ff   <= tbl_rd_ff.off;
                     best_len_ff   <= tbl_rd_ff.len;
                  end
               end
               S_RSCAN: begin
                  if (!tbl_rd_ff.vld) begin
                     if (!hole_found_ff) begin
                        hole_found_ff <= 1'b1;
                        hole_idx_ff   <= chk_idx_ff;
                     end
                  end else begin
                     if ((END_W'(fifo_head.off) < e_end) &&
                         (END_W'(tbl_rd_ff.off) < b_end)) begin
                        ovl_ff <= 1'b1;
                     end
                     if (e_end == END_W'(fifo_head.off)) begin
                        prev_found_ff <= 1'b1;
                        prev_idx_ff   <= chk_idx_ff;
                        prev_off_ff   <= tbl_rd_ff.off;
                        prev_len_ff   <= tbl_rd_ff.len;
                     end
                     if (END_W'(tbl_rd_ff.off) == b_end) begin
                        next_found_ff <= 1'b1;
                        next_idx_ff   <= chk_idx_ff;
                        next_len_ff   <= tbl_rd_ff.len;
                     end
                  end
               end
               S_LSCAN: begin
                  if (tbl_rd_ff.vld && (tbl_rd_ff.len > lg_acc_ff)) begin
                     lg_acc_ff <= tbl_rd_ff.len;
                  end
               end
               default: lg_acc_ff <= lg_acc_ff;
            endcase
         end
      end
   end

   // Sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         hs_ff        <= SLOT_W'(MAX_SLOTS);
         free_ff      <= SLOT_W'(MAX_SLOTS);
         largest_ff   <= SLOT_W'(MAX_SLOTS);
         base_ff      <= '0;
         stride_ff    <= STRIDE_W'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one loads this cycle
         if (rsp_valid_ff && rsp_ready && ((state_ff != S_RESP) || heap_wr)) begin
            rsp_valid_ff <= 1'b0;
         end

         // A heap size write restarts the clearing pass
         if (heap_wr) begin
            free_ff    <= hs_new;
            largest_ff <= hs_new;
            clr_cnt_ff <= '0;
            state_ff   <= S_CLEAR;
         end else begin
            case (state_ff)
               S_CLEAR: begin
                  clr_cnt_ff <= clr_cnt_ff + 1'b1;
                  if (clr_cnt_ff == (TBL_AW+1)'(TBL_DEPTH - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (accept) begin
                     req_ff     <= req_data;
                     gnt_off_ff <= '0;
                     gnt_cnt_ff <= '0;
                     handle_ff  <= '0;
                     status_ff  <= ST_OK;
                     case (req_data.operation)
                        OP_ALLOC: begin
                           if (alloc_ok) begin
                              state_ff <= S_ASCAN;
                           end else begin
                              status_ff <= ST_NOFIT;
                              state_ff  <= S_RESP;
                           end
                        end
                        OP_FREE: begin
                           status_ff <= fifo_sts.full ? ST_FULL : ST_OK;
                           state_ff  <= S_RESP;
                        end
                        OP_RELEASE: state_ff <= S_RHEAD;
                        default:    state_ff <= S_RESP;
                     endcase
                  end
               end
               S_ASCAN: begin
                  if (scan_done) begin
                     if (best_found_ff) begin
                        state_ff <= S_AUPD;
                     end else begin
                        status_ff <= ST_NOFIT;
                        state_ff  <= S_RESP;
                     end
                  end
               end
               S_AUPD: begin
                  free_ff    <= free_ff - req_ff.request_count;
                  prod_ff    <= PROD_W'(best_off_ff) * PROD_W'(stride_ff);
                  gnt_off_ff <= best_off_ff;
                  gnt_cnt_ff <= req_ff.request_count;
                  state_ff   <= S_AHDL;
               end
               S_AHDL: begin
                  handle_ff <= base_ff + ADDR_W'(prod_ff);
                  state_ff  <= S_LSCAN;
               end
               S_RHEAD: state_ff <= S_RCHK;
               S_RCHK: begin
                  if (!rel_take) begin
                     state_ff <= S_LSCAN;
                  end else if (rel_bad) begin
                     state_ff <= S_RHEAD;
                  end else begin
                     state_ff <= S_RSCAN;
                  end
               end
               S_RSCAN: begin
                  if (scan_done) begin
                     if (rel_merge) begin
                        free_ff <= free_ff + fifo_head.len;
                     end
                     if (!ovl_ff && prev_found_ff && next_found_ff) begin
                        state_ff <= S_RUPD2;
                     end else begin
                        state_ff <= S_RHEAD;
                     end
                  end
               end
               S_RUPD2: state_ff <= S_RHEAD;
               S_LSCAN: begin
                  if (scan_done) begin
                     largest_ff <= lg_acc_ff;
                     state_ff   <= S_RESP;
                  end
               end
               S_RESP: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_ff                   <= 1'b1;
                     rsp_data_ff.status             <= status_ff;
                     rsp_data_ff.granted_offset     <= gnt_off_ff;
                     rsp_data_ff.granted_count      <= gnt_cnt_ff;
                     rsp_data_ff.descriptor_handle  <= handle_ff;
                     rsp_data_ff.free_total         <= free_ff;
                     rsp_data_ff.largest_free_block <= largest_ff;
                     state_ff                       <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end

         // Configuration writes
         if (csr_we) begin
            case (csr_index)
               CSR_HEAP_SIZE: hs_ff     <= hs_new;
               CSR_BASE_ADDR: base_ff   <= csr_wdata;
               CSR_STRIDE:    stride_ff <= csr_wdata[STRIDE_W-1:0];
               default:       base_ff   <= base_ff;
            endcase
         end
      end
   end

`ifndef NO_ASSERTIONS
   // Free slot count never exceeds the heap
   assert property (@(posedge clock) disable iff (reset) free_ff <= hs_ff)
      else $error("free slot count exceeds heap size");

   // A grant lies inside the heap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == ST_OK) && (rsp_data_ff.granted_count != '0))
      |-> (END_W'(rsp_data_ff.granted_offset) + END_W'(rsp_data_ff.granted_count)
           <= END_W'(hs_ff)))
      else $error("granted block reaches past the heap");

   // The table is never written while it is being scanned
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_ASCAN) || (state_ff == S_LSCAN) ||
       ((state_ff == S_RSCAN) && !scan_done)) |-> !tw_en)
      else $error("table written during scan");

   // Never pop an empty stale queue
   assert property (@(posedge clock) disable iff (reset)
      fifo_ctl.pop |-> !fifo_sts.empty)
      else $error("pop from empty stale queue");
`endif

endmodule

### sim/tb.sv
// Self-checking testbench for best_fit_block_allocator_core.
// Depends on bfba_pkg and the allocator RTL; it predicts each result in-line
// and compares every response against the predicted queue.
module tb;
   import bfba_pkg::*;

   localparam int CYCLE_LIMIT = 60_000_000;
   localparam int SETTLE      = 1200;
   // Operation code with no function
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   best_fit_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the allocator state
   int unsigned heap_slots;
   logic [63:0] heap_base;
   int unsigned slot_stride;
   int unsigned blk_off [TBL_DEPTH];
   int unsigned blk_len [TBL_DEPTH];
   bit          blk_vld [TBL_DEPTH];
   int unsigned slots_free;
   int unsigned stale_off [FIFO_DEPTH];
   int unsigned stale_len [FIFO_DEPTH];
   logic [63:0] stale_tag [FIFO_DEPTH];
   int unsigned stale_head, stale_count;

   rsp_type     pending_rsp [$];
   int unsigned live_off [$];
   int unsigned live_len [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          fail_count = 0;
   longint      cycle_count = 0;
   logic [63:0] frame_now = 64'd10;

   function automatic void clear_store();
      foreach (blk_vld[i]) blk_vld[i] = 1'b0;
      blk_off[0] = 0;
      blk_len[0] = heap_slots;
      blk_vld[0] = heap_slots > 0;
      slots_free = heap_slots;
      stale_head = 0;
      stale_count = 0;
      live_off.delete();
      live_len.delete();
   endfunction

   // Put a released block back, merging with neighbors; drop bad blocks
   function automatic void give_back(int unsigned off, int unsigned len);
      int prv, nxt, hole;
      prv = -1; nxt = -1; hole = -1;
      if (len == 0 || off + len > heap_slots) return;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         if (!blk_vld[i]) begin
            if (hole < 0) hole = i;
            continue;
         end
         if (off < blk_off[i] + blk_len[i] && blk_off[i] < off + len) return;
         if (blk_off[i] + blk_len[i] == off) prv = i;
         if (blk_off[i] == off + len) nxt = i;
      end
      if (prv >= 0) begin
         blk_len[prv] += len;
         if (nxt >= 0) begin
            blk_len[prv] += blk_len[nxt];
            blk_vld[nxt] = 1'b0;
         end
      end else if (nxt >= 0) begin
         blk_off[nxt] = off;
         blk_len[nxt] += len;
      end else if (hole >= 0) begin
         blk_off[hole] = off;
         blk_len[hole] = len;
         blk_vld[hole] = 1'b1;
      end else begin
         return;
      end
      slots_free += len;
   endfunction

   // Work out the result of one accepted item and update the shadow state
   function automatic rsp_type allocate_outcome(req_type r);
      rsp_type     o;
      int          best;
      int unsigned cnt, tail, biggest;
      o = '0;
      cnt = 32'(r.request_count);
      biggest = 0;
      if (r.operation == OP_ALLOC) begin
         best = -1;
         o.status = ST_NOFIT;
         if (cnt != 0 && cnt <= slots_free) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
               if (!blk_vld[i] || blk_len[i] < cnt) continue;
               if (best < 0 || blk_len[i] < blk_len[best] ||
                   (blk_len[i] == blk_len[best] && blk_off[i] < blk_off[best]))
                  best = i;
            end
         end
         if (best >= 0) begin
            o.status = ST_OK;
            o.granted_offset = OFF_W'(blk_off[best]);
            o.granted_count = SLOT_W'(cnt);
            o.descriptor_handle = heap_base + 64'(blk_off[best]) * 64'(slot_stride);
            live_off.push_back(blk_off[best]);
            live_len.push_back(cnt);
            if (blk_len[best] == cnt) blk_vld[best] = 1'b0;
            else begin
               blk_off[best] += cnt;
               blk_len[best] -= cnt;
            end
            slots_free -= cnt;
         end
      end else if (r.operation == OP_FREE) begin
         if (stale_count >= FIFO_DEPTH) o.status = ST_FULL;
         else begin
            tail = (stale_head + stale_count) % FIFO_DEPTH;
            stale_off[tail] = 32'(r.block_offset);
            stale_len[tail] = cnt;
            stale_tag[tail] = r.frame_number;
            stale_count++;
         end
      end else if (r.operation == OP_RELEASE) begin
         while (stale_count > 0 && stale_tag[stale_head] <= r.frame_number) begin
            give_back(stale_off[stale_head], stale_len[stale_head]);
            stale_head = (stale_head + 1) % FIFO_DEPTH;
            stale_count--;
         end
      end
      for (int i = 0; i < TBL_DEPTH; i++)
         if (blk_vld[i] && blk_len[i] > biggest) biggest = blk_len[i];
      o.free_total = SLOT_W'(slots_free);
      o.largest_free_block = SLOT_W'(biggest);
      return o;
   endfunction

   // Drive one item; hold valid across back-to-back items
   task automatic send_item(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(allocate_outcome(r));
   endtask

   task automatic send_op(input logic [1:0] op, input int unsigned cnt,
                          input int unsigned off, input logic [63:0] frame);
      req_type r;
      r.operation = op;
      r.request_count = cnt[SLOT_W-1:0];
      r.block_offset = off[OFF_W-1:0];
      r.frame_number = frame;
      send_item(r);
   endtask

   // Drop valid and wait until every predicted result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Present one register write for a cycle; the caller drops the enable
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      int unsigned v;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_HEAP_SIZE) begin
         v = 32'(val[10:0]);
         heap_slots = v > MAX_SLOTS ? MAX_SLOTS : v;
         clear_store();
      end else if (idx == CSR_BASE_ADDR) heap_base = val;
      else if (idx == CSR_STRIDE) slot_stride = 32'(val[8:0]);
   endtask

   // Randomize receiver ready each cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            rsp_type w;
            w = pending_rsp.pop_front();
            if (rsp_data.status !== w.status) begin
               $error("status exp %0d got %0d", w.status, rsp_data.status); fail_count++;
            end
            if (rsp_data.granted_offset !== w.granted_offset) begin
               $error("granted_offset exp %0d got %0d", w.granted_offset,
                      rsp_data.granted_offset); fail_count++;
            end
            if (rsp_data.granted_count !== w.granted_count) begin
               $error("granted_count exp %0d got %0d", w.granted_count,
                      rsp_data.granted_count); fail_count++;
            end
            if (rsp_data.descriptor_handle !== w.descriptor_handle) begin
               $error("descriptor_handle exp %h got %h", w.descriptor_handle,
                      rsp_data.descriptor_handle); fail_count++;
            end
            if (rsp_data.free_total !== w.free_total) begin
               $error("free_total exp %0d got %0d", w.free_total,
                      rsp_data.free_total); fail_count++;
            end
            if (rsp_data.largest_free_block !== w.largest_free_block) begin
               $error("largest_free_block exp %0d got %0d", w.largest_free_block,
                      rsp_data.largest_free_block); fail_count++;
            end
         end
      end
   end

   // Whole-heap grant, edge sizes, frame extremes, odd operation
   task automatic test_extremes();
      send_op(OP_ALLOC, 1024, 0, 64'd0);
      send_op(OP_ALLOC, 1, 0, 64'd0);
      send_op(OP_FREE, 1024, 0, 64'd5);
      send_op(OP_RELEASE, 0, 0, 64'd4);
      send_op(OP_RELEASE, 0, 0, 64'd5);
      send_op(OP_ALLOC, 0, 0, 64'd0);
      send_op(OP_ALLOC, 2047, 1023, '1);
      send_op(OP_UNUSED, 2047, 1023, '1);
      send_op(OP_FREE, 2047, 1023, '1);
      send_op(OP_FREE, 0, 7, 64'd0);
      send_op(OP_RELEASE, 0, 0, '1);
   endtask

   // Best fit, ties to lowest offset, coalescing, out-of-order tags
   task automatic test_best_fit();
      send_op(OP_ALLOC, 100, 0, 0);
      send_op(OP_ALLOC, 50, 0, 0);
      send_op(OP_ALLOC, 100, 0, 0);
      send_op(OP_ALLOC, 50, 0, 0);
      send_op(OP_FREE, 100, 0, 64'd20);
      send_op(OP_FREE, 100, 150, 64'd8);
      send_op(OP_RELEASE, 0, 0, 64'd10);
      send_op(OP_RELEASE, 0, 0, 64'd20);
      send_op(OP_ALLOC, 100, 0, 0);
      send_op(OP_FREE, 50, 100, 64'd21);
      send_op(OP_FREE, 10, 100, 64'd21);
      send_op(OP_RELEASE, 0, 0, 64'd21);
      send_op(OP_ALLOC, 60, 0, 0);
   endtask

   // Fill the stale queue past its depth, then flush it
   task automatic test_queue_full();
      for (int i = 0; i < FIFO_DEPTH + 2; i++)
         send_op(OP_FREE, $urandom_range(1, 40), $urandom_range(0, 1023),
                 {$urandom, $urandom});
      send_op(OP_RELEASE, 0, 0, '1);
   endtask

   // Mostly well-formed alloc/free/release traffic with some noise
   task automatic test_random_traffic(input int n);
      int unsigned k, pick, sz;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(1, heap_slots + 1)
                                           : $urandom_range(1, 48);
            send_op(OP_ALLOC, sz, $urandom, {$urandom, $urandom});
         end else if (pick < 72 && live_off.size() != 0) begin
            k = $urandom_range(live_off.size() - 1);
            send_op(OP_FREE, live_len[k], live_off[k], frame_now + $urandom_range(3));
            live_off.delete(k);
            live_len.delete(k);
         end else if (pick < 90) begin
            frame_now += $urandom_range(2);
            send_op(OP_RELEASE, $urandom, $urandom, frame_now);
         end else if (pick < 96) begin
            send_op(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023),
                    {$urandom, $urandom});
         end else begin
            send_op(2'($urandom_range(3)), $urandom_range(0, 2047),
                    $urandom_range(0, 1023), {$urandom, $urandom});
         end
         // Hold off once until the pipeline is empty
         if (i == n / 2) drain();
      end
   endtask

   // Drain and bring the heap back to a clean state with new registers
   task automatic reconfigure(input int unsigned size, input logic [63:0] base,
                              input int unsigned stride);
      drain();
      write_reg(CSR_BASE_ADDR, base);
      write_reg(CSR_STRIDE, 64'(stride));
      write_reg(CSR_HEAP_SIZE, 64'(size));
      csr_we <= 1'b0;
      frame_now = 64'd10;
   endtask

   initial begin
      heap_slots = MAX_SLOTS;
      heap_base = '0;
      slot_stride = 32;
      clear_store();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12; recv_idle_pct = 72;
      test_extremes();
      reconfigure(1024, '1, 256);
      test_best_fit();
      reconfigure(1, 64'h0123_4567_89ab_cdef, 1);
      send_op(OP_ALLOC, 1, 0, 0);
      send_op(OP_ALLOC, 1, 0, 0);
      reconfigure(2047, 64'h8000_0000_0000_0000, 7);
      test_queue_full();
      test_random_traffic(300);

      send_idle_pct = 72; recv_idle_pct = 12;
      reconfigure($urandom_range(64, 400), {$urandom, $urandom}, $urandom_range(1, 256));
      test_random_traffic(380);

      send_idle_pct = 0; recv_idle_pct = 0;
      reconfigure(1024, {$urandom, $urandom}, $urandom_range(1, 256));
      test_random_traffic(380);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d results never arrived", pending_rsp.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
